[rtl/core/bpc_pkg.sv]
// Shared types, widths and constants of the barometric pressure compensation core.
// No dependencies; bpc_if, bpc_div, the top level and the checker import this package.
package bpc_pkg;

  // Payload types of the request and result channels.
  typedef logic signed [23:0] raw_t;
  typedef logic signed [31:0] pa_t;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 41;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OSR           = 3'd0,
    CFG_OFFSET_LINEAR = 3'd1,
    CFG_TEMP_TERMS    = 3'd2,
    CFG_CROSS_TERMS   = 3'd3,
    CFG_HIGH_ORDER    = 3'd4
  } cfg_idx_t;

  localparam logic [2:0] OSR_RESET = 3'd3;

  // Divider operand width and the integer bits allowed in a quotient.
  localparam int DIV_W      = 30;
  localparam int T_LIM_BITS = 14;
  localparam int OUT_FRAC   = 6;
  localparam int SCALE_W    = 23;

  // Raw pressure scale factor for each oversampling code.
  function automatic logic [SCALE_W-1:0] osr_scale(input logic [2:0] code);
    logic [SCALE_W-1:0] s;
    unique case (code)
      3'd0:    s = 23'd524288;
      3'd1:    s = 23'd1572864;
      3'd2:    s = 23'd3670016;
      3'd3:    s = 23'd7864320;
      3'd4:    s = 23'd253952;
      3'd5:    s = 23'd516096;
      3'd6:    s = 23'd1040384;
      default: s = 23'd2088960;
    endcase
    return s;
  endfunction

endpackage

[rtl/core/bpc_if.sv]
// Channel interfaces of the compensation core: sample requests, results, configuration.
// Depends on bpc_pkg for payload types and port widths.
interface bpc_in_if;
  import bpc_pkg::*;
  logic valid;
  logic ready;
  raw_t raw_pressure;
  raw_t raw_temperature;
  modport source (output valid, raw_pressure, raw_temperature, input ready);
  modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;
  logic valid;
  logic ready;
  pa_t  pressure_pa;
  logic saturated;
  modport source (output valid, pressure_pa, saturated, input ready);
  modport sink (input valid, pressure_pa, saturated, output ready);
endinterface

interface bpc_cfg_if;
  import bpc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/core/bpc_dly.sv]
// Enabled delay line that keeps operands aligned with later pipeline stages.
// Depends on nothing but the clock enable of the core.
module bpc_dly #(
  parameter int W = 8,
  parameter int N = 3
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap [0:N-1];

  // Shift the word one stage per enabled cycle.
  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[N-1];

endmodule

[rtl/core/bpc_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with round and limit.
// Depends on bpc_pkg for the operand width and the quotient integer limit.
module bpc_div #(
  parameter int F = 32
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [bpc_pkg::DIV_W-1:0] num,
  input  logic [bpc_pkg::DIV_W-1:0] den,
  input  logic                      neg,
  input  logic                      over,
  output logic signed [F+bpc_pkg::T_LIM_BITS+1:0] q
);
  import bpc_pkg::*;

  localparam int QW = F + T_LIM_BITS + 1;

  logic [DIV_W-1:0] rem [0:QW];
  logic [QW-1:0]    low [0:QW];
  logic [QW-1:0]    quo [0:QW];
  logic [DIV_W-1:0] dv  [0:QW];
  logic             ng  [0:QW];
  logic             ov  [0:QW];

  // The integer part already fits below the limit, so the top bits seed the remainder.
  assign rem[0] = DIV_W'(num >> T_LIM_BITS);
  assign low[0] = {num[T_LIM_BITS-1:0], {(F+1){1'b0}}};
  assign quo[0] = '0;
  assign dv[0]  = den;
  assign ng[0]  = neg;
  assign ov[0]  = over;

  // One trial subtraction per stage.
  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DIV_W:0] trial;
    logic           take;
    always_comb begin
      trial = {rem[i], low[i][QW-1]};
      take  = trial >= {1'b0, dv[i]};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= take ? DIV_W'(trial - {1'b0, dv[i]}) : DIV_W'(trial);
        low[i+1] <= {low[i][QW-2:0], 1'b0};
        quo[i+1] <= {quo[i][QW-2:0], take};
        dv[i+1]  <= dv[i];
        ng[i+1]  <= ng[i];
        ov[i+1]  <= ov[i];
      end
    end
  end

  // Round the extra fraction bit away from zero, apply the limit and the sign.
  logic [QW:0]   inc;
  logic [QW-1:0] mag;
  always_comb begin
    inc = {1'b0, quo[QW]} + 1'b1;
    mag = ov[QW] ? {1'b1, {(QW-1){1'b0}}} : inc[QW:1];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= ng[QW] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

endmodule

[rtl/core/bpc_mul.sv]
// Three-stage signed multiplier from half-width partial products, with an optional
// rounding shift (ties away from zero). Depends on nothing outside this file.
module bpc_mul #(
  parameter int AW = 48,
  parameter int BW = 48,
  parameter int OW = 48,
  parameter int SH = 32
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [OW-1:0] y
);

  localparam int AL = AW / 2;
  localparam int BL = BW / 2;
  localparam int MW = AW + BW;

  logic [AW-1:0] am;
  logic [BW-1:0] bm;
  logic          sg1, sg2;
  logic [AL+BL-1:0]           p00;
  logic [AL+BW-BL-1:0]        p01;
  logic [AW-AL+BL-1:0]        p10;
  logic [AW-AL+BW-BL-1:0]     p11;
  logic [MW:0] sum, rnd;
  logic [OW-1:0] mag;

  // Split into sign and magnitude.
  always_ff @(posedge clk) begin
    if (en) begin
      am  <= AW'(a[AW-1] ? -a : a);
      bm  <= BW'(b[BW-1] ? -b : b);
      sg1 <= a[AW-1] ^ b[BW-1];
    end
  end

  // Partial products of the magnitude halves.
  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= am[AL-1:0] * bm[BL-1:0];
      p01 <= am[AL-1:0] * bm[BW-1:BL];
      p10 <= am[AW-1:AL] * bm[BL-1:0];
      p11 <= am[AW-1:AL] * bm[BW-1:BL];
      sg2 <= sg1;
    end
  end

  always_comb begin
    sum = (MW+1)'(p00) + ((MW+1)'(p01) << BL) + ((MW+1)'(p10) << AL)
        + ((MW+1)'(p11) << (AL + BL));
  end

  if (SH > 0) begin : g_round
    assign rnd = sum + ((MW+1)'(1) << (SH - 1));
  end else begin : g_exact
    assign rnd = sum;
  end

  assign mag = OW'(rnd >> SH);

  // Restore the sign.
  always_ff @(posedge clk) begin
    if (en) begin
      y <= sg2 ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

[rtl/core/baro_pressure_compensation_core.sv]
// Top level of the barometric pressure compensation core.
// Depends on bpc_pkg, bpc_if, bpc_dly, bpc_div and bpc_mul.

// The core accepts one raw pressure and temperature pair per clock cycle unless stalled and
// returns one compensated pressure (signed Q25.6, saturated with a flag) per pair, in order.
// Most of the latency lies in the two bit-per-stage dividers that form the scaled pressure
// and the temperature term; the polynomial follows in three rounds of three-stage multipliers,
// two adder stages, a rounding stage and a saturating output stage. When the result is not
// taken, the whole pipeline holds and nothing is lost. Configuration writes are always
// accepted and take effect at once, so they must only be made while the core is empty.
module baro_pressure_compensation_core #(
  parameter int INTERNAL_FRAC_BITS = 32
) (
  input logic          clk,
  input logic          rst,
  bpc_cfg_if.sink      cfg,
  bpc_in_if.sink       sample,
  bpc_out_if.source    result
);
  import bpc_pkg::*;

  localparam int F   = INTERNAL_FRAC_BITS;
  localparam int QW  = F + T_LIM_BITS + 1;
  localparam int TW  = QW + 1;
  localparam int PW  = F + 8;
  localparam int PPW = F + 12;
  localparam int TTW = F + 30;
  localparam int TPW = F + 22;
  localparam int P3W = F + 18;
  localparam int TPPW = F + 37;
  localparam int PPTW = F + 27;
  localparam int SW  = F + 58;
  localparam int OMW = SW - F + OUT_FRAC;
  localparam int LAT = F + 31;

  // Configuration registers.
  logic [2:0]  osr;
  logic [39:0] w_offset_linear;
  logic [39:0] w_temp_terms;
  logic [33:0] w_cross_terms;
  logic [40:0] w_high_order;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      osr             <= OSR_RESET;
      w_offset_linear <= '0;
      w_temp_terms    <= '0;
      w_cross_terms   <= '0;
      w_high_order    <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_OSR:           osr             <= cfg.data[2:0];
        CFG_OFFSET_LINEAR: w_offset_linear <= cfg.data[39:0];
        CFG_TEMP_TERMS:    w_temp_terms    <= cfg.data[39:0];
        CFG_CROSS_TERMS:   w_cross_terms   <= cfg.data[33:0];
        CFG_HIGH_ORDER:    w_high_order    <= cfg.data[40:0];
        default: ;
      endcase
    end
  end

  // Coefficient fields.
  logic signed [19:0] c00, c10, c01, c02;
  logic signed [16:0] c11, c12;
  logic signed [14:0] c20;
  logic signed [13:0] c21;
  logic signed [11:0] c30;
  assign c00 = w_offset_linear[39:20];
  assign c10 = w_offset_linear[19:0];
  assign c01 = w_temp_terms[39:20];
  assign c02 = w_temp_terms[19:0];
  assign c11 = w_cross_terms[33:17];
  assign c12 = w_cross_terms[16:0];
  assign c20 = w_high_order[40:26];
  assign c21 = w_high_order[25:12];
  assign c30 = w_high_order[11:0];

  // Pipeline control: the whole pipeline advances while the output can move.
  logic [LAT-1:0] vp;
  logic           en;
  assign en           = !vp[LAT-1] || result.ready;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= '0;
    end else if (en) begin
      vp <= {vp[LAT-2:0], sample.valid};
    end
  end

  // Stage A: temperature numerator and divisor, pressure scale factor.
  logic signed [31:0]  rt_ext;
  logic signed [30:0]  num_a, den_a;
  raw_t                rp_a;
  logic [SCALE_W-1:0]  scale_a;
  assign rt_ext = 32'(sample.raw_temperature);

  always_ff @(posedge clk) begin
    if (en) begin
      num_a   <= 31'(rt_ext * 32'sd85);
      den_a   <= 31'(32'sd10485760 + rt_ext * 32'sd88);
      rp_a    <= sample.raw_pressure;
      scale_a <= osr_scale(osr);
    end
  end

  // Stage B: magnitudes, quotient signs and the limit check.
  logic [DIV_W-1:0] n_t, d_t, n_p, d_p;
  logic [DIV_W-1:0] n_t_b, d_t_b, n_p_b, d_p_b;
  logic             neg_t_b, ov_t_b, neg_p_b, ov_p_b;
  always_comb begin
    n_t = DIV_W'(num_a[30] ? -num_a : num_a);
    d_t = DIV_W'(den_a[30] ? -den_a : den_a);
    n_p = DIV_W'(rp_a[23] ? -rp_a : rp_a);
    d_p = DIV_W'(scale_a);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_t_b   <= n_t;
      d_t_b   <= d_t;
      neg_t_b <= num_a[30] ^ den_a[30];
      ov_t_b  <= {{T_LIM_BITS{1'b0}}, n_t} >= {d_t, {T_LIM_BITS{1'b0}}};
      n_p_b   <= n_p;
      d_p_b   <= d_p;
      neg_p_b <= rp_a[23];
      ov_p_b  <= {{T_LIM_BITS{1'b0}}, n_p} >= {d_p, {T_LIM_BITS{1'b0}}};
    end
  end

  // Scaled pressure and temperature term.
  logic signed [TW-1:0] p_full, t_val;
  logic signed [PW-1:0] p_val;

  bpc_div #(.F(F)) u_div_p (
    .clk, .en, .num(n_p_b), .den(d_p_b), .neg(neg_p_b), .over(ov_p_b), .q(p_full)
  );
  bpc_div #(.F(F)) u_div_t (
    .clk, .en, .num(n_t_b), .den(d_t_b), .neg(neg_t_b), .over(ov_t_b), .q(t_val)
  );
  assign p_val = PW'(p_full);

  // First product round: p^2, t^2, t*p.
  logic signed [PPW-1:0] pp;
  logic signed [TTW-1:0] tt;
  logic signed [TPW-1:0] tp;
  bpc_mul #(.AW(PW), .BW(PW), .OW(PPW), .SH(F)) u_pp (.clk, .en, .a(p_val), .b(p_val), .y(pp));
  bpc_mul #(.AW(TW), .BW(TW), .OW(TTW), .SH(F)) u_tt (.clk, .en, .a(t_val), .b(t_val), .y(tt));
  bpc_mul #(.AW(TW), .BW(PW), .OW(TPW), .SH(F)) u_tp (.clk, .en, .a(t_val), .b(p_val), .y(tp));

  logic signed [PW-1:0] p_d3, p_d6;
  logic signed [TW-1:0] t_d3, t_d6;
  bpc_dly #(.W(PW), .N(3)) u_dly_p3 (.clk, .en, .d(p_val), .q(p_d3));
  bpc_dly #(.W(PW), .N(3)) u_dly_p6 (.clk, .en, .d(p_d3), .q(p_d6));
  bpc_dly #(.W(TW), .N(3)) u_dly_t3 (.clk, .en, .d(t_val), .q(t_d3));
  bpc_dly #(.W(TW), .N(3)) u_dly_t6 (.clk, .en, .d(t_d3), .q(t_d6));

  // Second product round: p^3, p*t^2, p^2*t.
  logic signed [P3W-1:0]  ppp;
  logic signed [TPPW-1:0] ttp;
  logic signed [PPTW-1:0] ppt;
  bpc_mul #(.AW(PPW), .BW(PW), .OW(P3W), .SH(F)) u_ppp (.clk, .en, .a(pp), .b(p_d3), .y(ppp));
  bpc_mul #(.AW(TTW), .BW(PW), .OW(TPPW), .SH(F)) u_ttp (.clk, .en, .a(tt), .b(p_d3), .y(ttp));
  bpc_mul #(.AW(PPW), .BW(TW), .OW(PPTW), .SH(F)) u_ppt (.clk, .en, .a(pp), .b(t_d3), .y(ppt));

  logic signed [PPW-1:0] pp_d3;
  logic signed [TTW-1:0] tt_d3;
  logic signed [TPW-1:0] tp_d3;
  bpc_dly #(.W(PPW), .N(3)) u_dly_pp (.clk, .en, .d(pp), .q(pp_d3));
  bpc_dly #(.W(TTW), .N(3)) u_dly_tt (.clk, .en, .d(tt), .q(tt_d3));
  bpc_dly #(.W(TPW), .N(3)) u_dly_tp (.clk, .en, .d(tp), .q(tp_d3));

  // Coefficient products, all exact.
  logic signed [PW+19:0]   m10;
  logic signed [TW+19:0]   m01;
  logic signed [PPW+14:0]  m20;
  logic signed [TTW+19:0]  m02;
  logic signed [P3W+11:0]  m30;
  logic signed [TPW+16:0]  m11;
  logic signed [TPPW+16:0] m12;
  logic signed [PPTW+13:0] m21;
  bpc_mul #(.AW(PW), .BW(20), .OW(PW+20), .SH(0)) u_m10 (.clk, .en, .a(p_d6), .b(c10), .y(m10));
  bpc_mul #(.AW(TW), .BW(20), .OW(TW+20), .SH(0)) u_m01 (.clk, .en, .a(t_d6), .b(c01), .y(m01));
  bpc_mul #(.AW(PPW), .BW(15), .OW(PPW+15), .SH(0)) u_m20 (
    .clk, .en, .a(pp_d3), .b(c20), .y(m20));
  bpc_mul #(.AW(TTW), .BW(20), .OW(TTW+20), .SH(0)) u_m02 (
    .clk, .en, .a(tt_d3), .b(c02), .y(m02));
  bpc_mul #(.AW(P3W), .BW(12), .OW(P3W+12), .SH(0)) u_m30 (
    .clk, .en, .a(ppp), .b(c30), .y(m30));
  bpc_mul #(.AW(TPW), .BW(17), .OW(TPW+17), .SH(0)) u_m11 (
    .clk, .en, .a(tp_d3), .b(c11), .y(m11));
  bpc_mul #(.AW(TPPW), .BW(17), .OW(TPPW+17), .SH(0)) u_m12 (
    .clk, .en, .a(ttp), .b(c12), .y(m12));
  bpc_mul #(.AW(PPTW), .BW(14), .OW(PPTW+14), .SH(0)) u_m21 (
    .clk, .en, .a(ppt), .b(c21), .y(m21));

  // Sum of the nine terms in two adder stages.
  logic signed [SW-1:0] k00, g0, g1, g2, s_sum;
  assign k00 = SW'(c00) <<< F;

  always_ff @(posedge clk) begin
    if (en) begin
      g0 <= k00 + SW'(m10) + SW'(m01);
      g1 <= SW'(m20) + SW'(m02) + SW'(m30);
      g2 <= SW'(m11) + SW'(m12) + SW'(m21);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_sum <= g0 + g1 + g2;
    end
  end

  // Round to the output fraction bits, ties away from zero.
  logic [SW-1:0]  s_mag;
  logic [OMW-1:0] om;
  logic           om_neg;
  assign s_mag = SW'(s_sum[SW-1] ? -s_sum : s_sum) + (SW'(1) << (F - OUT_FRAC - 1));

  always_ff @(posedge clk) begin
    if (en) begin
      om     <= OMW'(s_mag >> (F - OUT_FRAC));
      om_neg <= s_sum[SW-1];
    end
  end

  // Saturate to the output range and register the result.
  logic pos_over, neg_over;
  assign pos_over = om > OMW'(32'h7FFF_FFFF);
  assign neg_over = om > OMW'(33'h1_0000_0000 >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      if (om_neg) begin
        result.saturated   <= neg_over;
        result.pressure_pa <= neg_over ? pa_t'(32'h8000_0000) : pa_t'(-om);
      end else begin
        result.saturated   <= pos_over;
        result.pressure_pa <= pos_over ? pa_t'(32'h7FFF_FFFF) : pa_t'(om);
      end
    end
  end

  assign result.valid = vp[LAT-1];

endmodule

[rtl/core/bpc_checker.sv]
// Port-level checks of the compensation core, bound to the top level.
// Depends on bpc_pkg and on the ports of baro_pressure_compensation_core.
module bpc_sva (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input bpc_pkg::pa_t  pressure_pa,
  input logic          saturated
);
  import bpc_pkg::*;

  // A held result keeps its value.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pressure_pa) && $stable(saturated))
    else $error("result changed while stalled");

  // A saturated result sits at one end of the range.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> pressure_pa == 32'sh7FFF_FFFF || pressure_pa == 32'sh8000_0000)
    else $error("saturated flag without a clipped value");

  // Reset empties the pipeline.
  a_rst: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown after reset");

  // An empty output never blocks new requests.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("request refused with idle output");

  // A request that is refused is only refused while a result waits.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |-> out_valid && !out_ready)
    else $error("request refused without an output stall");

endmodule

bind baro_pressure_compensation_core bpc_sva u_bpc_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (sample.valid),
  .in_ready    (sample.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .pressure_pa (result.pressure_pa),
  .saturated   (result.saturated)
);
